// File: hdl/mlfq_psjf_thread_scheduler_top_assert.svh
// assertion macros for the thread scheduler
`ifndef MLFQ_PSJF_THREAD_SCHEDULER_TOP_ASSERT_SVH
`define MLFQ_PSJF_THREAD_SCHEDULER_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define MPTS_ASSERT_NOW(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("scheduler check failed");

// condition implies consequence in the next cycle
`define MPTS_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("scheduler check failed");

`endif

// File: hdl/mpts_pkg.sv
package mpts_pkg;

	localparam int MAX_THREADS = 16;
	localparam int NUM_LEVELS  = 4;
	localparam int TID_W       = $clog2(MAX_THREADS);
	localparam int CNT_W       = TID_W + 1;
	localparam int LVL_W       = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int QT_W        = 16;
	localparam logic [QT_W-1:0] RESET_QUANTUM = 16'd10;

	typedef enum logic [2:0] {
		OP_CREATE = 3'd0,
		OP_TICK   = 3'd1,
		OP_YIELD  = 3'd2,
		OP_EXIT   = 3'd3,
		OP_JOIN   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL   = 2'd2,
		ST_HALTED = 2'd3
	} status_t;

	localparam logic CFG_POLICY  = 1'b0;
	localparam logic CFG_QUANTUM = 1'b1;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [QT_W-1:0]  elapsed;
		logic [QT_W-1:0]  ticks;
		logic [TID_W-1:0] rank;
		logic [TID_W:0]   waiter;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	localparam ent_t ENT_RESET = '{level: '0, elapsed: '0, ticks: RESET_QUANTUM,
		rank: '0, waiter: '0};

endpackage

// File: hdl/mlfq_psjf_thread_scheduler_top.sv
// thread scheduler: multilevel feedback queue or shortest elapsed first
// input channel: in_valid / in_stall, payload op and join_tid; one event
// per transfer, taken only while the sequencer is idle
// output channel: out_valid / out_stall, one result per event, held in an
// output register so the next event is taken while a result still waits
// config: cfg_we writes policy_mode (index 0) or quantum_ticks (index 1)
// sequence: create, a refused join or any event while halted go straight
// to the result; a tick without expiry adds the read-modify-write of the
// running entry; an event that reschedules does that read-modify-write
// (plus the join target), a scan of the thread table through the single
// read port of the ram, and a pass that closes the gap in the fifo ranks
// reset: thread 0 runs, its entry reads as level 0 with a full quantum;
// entries of the ram count as unwritten until a write marks them
// halted: once no thread is ready, every event gives status halted
// a stalled output holds the result and the sequencer waits to load the next
module mlfq_psjf_thread_scheduler_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] op,
	input  logic [3:0] join_tid,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] running_tid,
	output logic       running_valid,
	output logic [3:0] new_tid,
	output logic       switched,
	output logic [1:0] status,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int TW = mpts_pkg::TID_W;
	localparam int CW = mpts_pkg::CNT_W;
	localparam int MT = mpts_pkg::MAX_THREADS;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_TGT   = 6'b000010,
		S_CUR   = 6'b000100,
		S_SCAN  = 6'b001000,
		S_SWEEP = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	// configuration
	logic                      policy_q;
	logic [mpts_pkg::QT_W-1:0] quantum_q;

	// per-thread flags kept in flops, the rest of the entry lives in the ram
	logic [MT-1:0] valid_q;
	logic [MT-1:0] blocked_q;
	logic [MT-1:0] wr_q;
	logic [CW-1:0] nvalid_q;
	logic [TW-1:0] cur_q;
	logic          halted_q;

	// event registers
	logic [2:0]    op_q;
	logic [TW-1:0] tgt_q;
	logic [TW-1:0] res_new_q;
	logic [1:0]    res_status_q;
	logic          res_sw_q;

	// scan and sweep
	logic [CW-1:0]             cnt_q;
	logic                      best_found_q;
	logic [TW-1:0]             best_idx_q;
	logic [mpts_pkg::QT_W-1:0] best_key_q;
	logic [TW-1:0]             best_rank_q;

	// table ram
	logic           ram_we;
	logic [TW-1:0]  ram_waddr;
	mpts_pkg::ent_t ram_wdata;
	logic [TW-1:0]  rd_addr;
	logic           rd_en;
	logic [mpts_pkg::ENT_W-1:0] ram_rdata;
	logic [TW-1:0]  rd_idx_s1;
	logic           rd_v_s1;
	mpts_pkg::ent_t rd_ent;

	// output register
	logic          out_valid_q;
	logic [TW-1:0] out_run_q;
	logic          out_rv_q;
	logic [TW-1:0] out_new_q;
	logic          out_sw_q;
	logic [1:0]    out_status_q;

	logic in_acc;
	logic [TW-1:0] free_idx;
	logic          free_found;
	logic [TW-1:0] qlen;
	logic          tgt_bad;
	logic [mpts_pkg::QT_W-1:0] scan_key;
	logic          scan_elig;
	logic          scan_take;
	logic          scan_last;
	logic          found_next;
	logic          expire;
	logic [TW:0]   waiter_cur;
	logic [MT-1:0] wake_mask;

	mpts_ram #(.WIDTH(mpts_pkg::ENT_W), .DEPTH(MT)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// an entry never written reads as its reset contents
	assign rd_ent = wr_q[rd_idx_s1] ? mpts_pkg::ent_t'(ram_rdata) : mpts_pkg::ENT_RESET;

	// queue length: every valid thread but the running one
	assign qlen = TW'(nvalid_q - CW'(1));

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = 0; i < MT; i++) begin
			if (!valid_q[i] && !free_found) begin
				free_found = 1'b1;
				free_idx   = TW'(i);
			end
		end
	end

	assign tgt_bad = ({1'b0, TW'(join_tid)} >= CW'(MT)) || !valid_q[TW'(join_tid)]
		|| (TW'(join_tid) == cur_q);

	// scan compare: level or elapsed first, then fifo rank
	assign scan_key  = policy_q ? rd_ent.elapsed : mpts_pkg::QT_W'(rd_ent.level);
	assign scan_elig = valid_q[rd_idx_s1] && !blocked_q[rd_idx_s1];
	assign scan_take = scan_elig && (!best_found_q || (scan_key < best_key_q)
		|| ((scan_key == best_key_q) && (rd_ent.rank < best_rank_q)));
	assign scan_last = rd_v_s1 && (rd_idx_s1 == TW'(MT - 1));
	assign found_next = best_found_q || scan_take;

	assign expire     = (rd_ent.ticks <= mpts_pkg::QT_W'(1));
	assign waiter_cur = rd_ent.waiter;

	// waiter released when the running thread exits
	assign wake_mask = ((waiter_cur != '0) && (waiter_cur <= (TW + 1)'(MT)))
		? (MT'(1) << (waiter_cur - (TW + 1)'(1))) : '0;

	// ram read and write selection
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = cur_q;
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = rd_ent;
		case (state_q)
			S_IDLE: begin
				if (in_acc && !halted_q) begin
					if (op == mpts_pkg::OP_CREATE) begin
						ram_we    = free_found;
						ram_waddr = free_idx;
						ram_wdata = '{level: '0, elapsed: '0, ticks: quantum_q,
							rank: qlen, waiter: '0};
					end else if (op == mpts_pkg::OP_JOIN) begin
						rd_en   = !tgt_bad;
						rd_addr = TW'(join_tid);
					end else if (op == mpts_pkg::OP_TICK || op == mpts_pkg::OP_YIELD
						|| op == mpts_pkg::OP_EXIT) begin
						rd_en = 1'b1;
					end
				end
			end
			S_TGT: begin
				ram_we           = 1'b1;
				ram_waddr        = tgt_q;
				ram_wdata.waiter = {1'b0, cur_q} + (TW + 1)'(1);
				rd_en            = 1'b1;
			end
			S_CUR: begin
				ram_we = 1'b1;
				case (op_q)
					mpts_pkg::OP_TICK: begin
						if (expire) begin
							if (rd_ent.elapsed != '1) begin
								ram_wdata.elapsed = rd_ent.elapsed + mpts_pkg::QT_W'(1);
							end
							if (rd_ent.level != mpts_pkg::LVL_W'(mpts_pkg::NUM_LEVELS - 1)) begin
								ram_wdata.level = rd_ent.level + mpts_pkg::LVL_W'(1);
							end
							ram_wdata.ticks = quantum_q;
							ram_wdata.rank  = qlen;
						end else begin
							ram_wdata.ticks = rd_ent.ticks - mpts_pkg::QT_W'(1);
						end
					end
					mpts_pkg::OP_EXIT: begin
						ram_wdata.rank   = '0;
						ram_wdata.waiter = '0;
					end
					default: begin
						ram_wdata.rank = qlen;
					end
				endcase
			end
			S_SCAN: begin
				rd_en   = (cnt_q < CW'(MT));
				rd_addr = cnt_q[TW-1:0];
			end
			S_SWEEP: begin
				rd_en     = (cnt_q < CW'(MT));
				rd_addr   = cnt_q[TW-1:0];
				ram_waddr = rd_idx_s1;
				if (rd_v_s1) begin
					if (rd_idx_s1 == best_idx_q) begin
						ram_we         = 1'b1;
						ram_wdata.rank = '0;
					end else if (valid_q[rd_idx_s1] && (rd_ent.rank > best_rank_q)) begin
						ram_we         = 1'b1;
						ram_wdata.rank = rd_ent.rank - TW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= 1'b0;
			quantum_q <= mpts_pkg::RESET_QUANTUM;
		end else if (cfg_we) begin
			if (cfg_index == mpts_pkg::CFG_POLICY) begin
				policy_q <= cfg_data[0];
			end else begin
				quantum_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= MT'(1);
			blocked_q    <= '0;
			wr_q         <= '0;
			nvalid_q     <= CW'(1);
			cur_q        <= '0;
			halted_q     <= 1'b0;
			rd_v_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
			best_found_q <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			if (ram_we) begin
				wr_q[ram_waddr] <= 1'b1;
			end
			// the done state reloads the output register itself
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q         <= op;
						tgt_q        <= TW'(join_tid);
						res_new_q    <= '0;
						res_status_q <= mpts_pkg::ST_OK;
						res_sw_q     <= 1'b0;
						state_q      <= S_DONE;
						if (!halted_q) begin
							case (op)
								mpts_pkg::OP_CREATE: begin
									if (free_found) begin
										valid_q[free_idx]   <= 1'b1;
										blocked_q[free_idx] <= 1'b0;
										nvalid_q            <= nvalid_q + CW'(1);
										res_new_q           <= free_idx;
									end else begin
										res_status_q <= mpts_pkg::ST_FULL;
									end
								end
								mpts_pkg::OP_TICK, mpts_pkg::OP_YIELD,
								mpts_pkg::OP_EXIT: begin
									state_q <= S_CUR;
								end
								mpts_pkg::OP_JOIN: begin
									if (tgt_bad) begin
										res_status_q <= mpts_pkg::ST_ABSENT;
									end else begin
										state_q <= S_TGT;
									end
								end
								default: begin
								end
							endcase
						end
					end
				end
				S_TGT: begin
					blocked_q[cur_q] <= 1'b1;
					state_q          <= S_CUR;
				end
				S_CUR: begin
					cnt_q        <= '0;
					best_found_q <= 1'b0;
					state_q      <= (op_q == mpts_pkg::OP_TICK && !expire) ? S_DONE : S_SCAN;
					if (op_q == mpts_pkg::OP_EXIT) begin
						// wake the waiter, then free the slot
						blocked_q <= blocked_q & ~wake_mask & ~(MT'(1) << cur_q);
						valid_q[cur_q] <= 1'b0;
						nvalid_q       <= nvalid_q - CW'(1);
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (rd_v_s1 && scan_take) begin
						best_found_q <= 1'b1;
						best_idx_q   <= rd_idx_s1;
						best_key_q   <= scan_key;
						best_rank_q  <= rd_ent.rank;
					end
					if (scan_last) begin
						cnt_q <= '0;
						if (found_next) begin
							state_q <= S_SWEEP;
						end else begin
							halted_q <= 1'b1;
							state_q  <= S_DONE;
						end
					end
				end
				S_SWEEP: begin
					if (rd_en) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (scan_last) begin
						cur_q    <= best_idx_q;
						halted_q <= 1'b0;
						res_sw_q <= 1'b1;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_run_q    <= halted_q ? '0 : cur_q;
						out_rv_q     <= !halted_q;
						out_new_q    <= res_new_q;
						out_sw_q     <= res_sw_q;
						out_status_q <= halted_q ? mpts_pkg::ST_HALTED : res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign running_tid   = 4'(out_run_q);
	assign running_valid = out_rv_q;
	assign new_tid       = 4'(out_new_q);
	assign switched      = out_sw_q;
	assign status        = out_status_q;

	`include "mlfq_psjf_thread_scheduler_top_assert.svh"

	// the live thread count tracks the valid flags
	`MPTS_ASSERT_NOW(a_nvalid, 1'b1, nvalid_q == CW'($countones(valid_q)))
	// between events the running thread is valid and not blocked
	`MPTS_ASSERT_NOW(a_runner, (state_q == S_IDLE) && !halted_q,
		valid_q[cur_q] && !blocked_q[cur_q])
	// a halted result never names a running thread
	`MPTS_ASSERT_NOW(a_halt_out, out_valid_q && (out_status_q == mpts_pkg::ST_HALTED),
		!out_rv_q && (out_run_q == '0))
	// once halted the block stays halted
	`MPTS_ASSERT_NEXT(a_halt_sticky, halted_q && (state_q == S_IDLE), halted_q)

endmodule

// File: hdl/mpts_ram.sv
module mpts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: verif/tb_mlfq_psjf_thread_scheduler_top.sv
`timescale 1ns / 100ps

module tb_mlfq_psjf_thread_scheduler_top;

	localparam int NT = mpts_pkg::MAX_THREADS;

	// ops outside the defined set, accepted with no effect
	localparam logic [2:0] OP_SPARE_LO  = 3'd5;
	localparam logic [2:0] OP_SPARE_MID = 3'd6;
	localparam logic [2:0] OP_SPARE_HI  = 3'd7;
	localparam logic [3:0] TID_TOP     = 4'd15;
	localparam int IDLE_LIMIT   = 4000;  // cycles with no transfer on either side
	localparam int SETTLE_CYCLES = 60;   // margin for a rescheduling event to finish
	localparam int ITEMS_PER_PHASE = 68;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  op;
	logic [3:0]  join_tid;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  running_tid;
	logic        running_valid;
	logic [3:0]  new_tid;
	logic        switched;
	logic [1:0]  status;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	mlfq_psjf_thread_scheduler_top u_dut (.*);

	typedef struct {
		logic [3:0]        tid;
		logic              run_ok;
		logic [3:0]        created;
		logic              sw;
		mpts_pkg::status_t st;
	} sched_result_t;

	typedef struct {
		logic [2:0]    o;
		logic [3:0]    tgt;
		bit            fixed;  // expectation typed in below
		sched_result_t res;
	} event_row_t;

	// shadow copy of the scheduler state
	logic                       mode_psjf;
	logic [15:0]                quantum;
	logic                       slot_used   [NT];
	logic                       slot_blocked[NT];
	logic [mpts_pkg::LVL_W-1:0] slot_level  [NT];
	logic [15:0]                slot_elapsed[NT];
	logic [15:0]                slot_ticks  [NT];
	logic [3:0]                 slot_rank   [NT];
	logic [4:0]                 slot_waiter [NT];
	logic [3:0]                 cur_tid;
	logic                       stopped;

	sched_result_t pending_results[$];
	int            fail_count;
	int            hold_requests;
	int            idle_cycles;

	// clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int waiting_count();
		int n = 0;
		for (int i = 0; i < NT; i++)
			if (slot_used[i] && !(i == cur_tid && !stopped))
				n++;
		return n;
	endfunction

	// requeue the runner if asked, then pick the next ready thread
	function automatic bit reschedule(bit requeue);
		int  pick = -1;
		bit  better;
		logic [3:0] r;
		if (requeue)
			slot_rank[cur_tid] = 4'(waiting_count());
		stopped = 1'b1;
		for (int i = 0; i < NT; i++) begin
			if (!slot_used[i] || slot_blocked[i])
				continue;
			if (pick < 0) begin
				pick = i;
				continue;
			end
			if (mode_psjf)
				better = slot_elapsed[i] < slot_elapsed[pick] ||
					(slot_elapsed[i] == slot_elapsed[pick] && slot_rank[i] < slot_rank[pick]);
			else
				better = slot_level[i] < slot_level[pick] ||
					(slot_level[i] == slot_level[pick] && slot_rank[i] < slot_rank[pick]);
			if (better)
				pick = i;
		end
		if (pick < 0)
			return 1'b0;
		r = slot_rank[pick];
		for (int i = 0; i < NT; i++)
			if (slot_used[i] && i != pick && slot_rank[i] > r)
				slot_rank[i]--;
		slot_rank[pick] = '0;
		cur_tid = 4'(pick);
		stopped = 1'b0;
		return 1'b1;
	endfunction

	function automatic sched_result_t apply_event(logic [2:0] o, logic [3:0] tgt);
		sched_result_t res;
		int  slot = -1;
		logic [3:0] c;
		res.created = '0;
		res.sw = 1'b0;
		res.st = mpts_pkg::ST_OK;
		if (!stopped) begin
			c = cur_tid;
			case (o)
				mpts_pkg::OP_CREATE: begin
					for (int i = NT - 1; i >= 0; i--)
						if (!slot_used[i])
							slot = i;
					if (slot < 0) begin
						res.st = mpts_pkg::ST_FULL;
					end else begin
						slot_rank[slot]    = 4'(waiting_count());
						slot_used[slot]    = 1'b1;
						slot_blocked[slot] = 1'b0;
						slot_level[slot]   = '0;
						slot_elapsed[slot] = '0;
						slot_ticks[slot]   = quantum;
						slot_waiter[slot]  = '0;
						res.created = 4'(slot);
					end
				end
				mpts_pkg::OP_TICK: begin
					if (slot_ticks[c] <= 16'd1) begin
						if (slot_elapsed[c] != 16'hffff)
							slot_elapsed[c]++;
						if (slot_level[c] + 1 < mpts_pkg::NUM_LEVELS)
							slot_level[c]++;
						slot_ticks[c] = quantum;
						res.sw = reschedule(1'b1);
					end else begin
						slot_ticks[c]--;
					end
				end
				mpts_pkg::OP_YIELD: res.sw = reschedule(1'b1);
				mpts_pkg::OP_EXIT: begin
					if (slot_waiter[c] != 0)
						slot_blocked[slot_waiter[c] - 1] = 1'b0;
					slot_used[c]    = 1'b0;
					slot_blocked[c] = 1'b0;
					slot_waiter[c]  = '0;
					slot_rank[c]    = '0;
					res.sw = reschedule(1'b0);
				end
				mpts_pkg::OP_JOIN: begin
					if (!slot_used[tgt] || tgt == c) begin
						res.st = mpts_pkg::ST_ABSENT;
					end else begin
						slot_blocked[c] = 1'b1;
						slot_waiter[tgt] = 5'(c) + 5'd1;
						res.sw = reschedule(1'b1);
					end
				end
				default: ;
			endcase
		end
		if (stopped)
			res.st = mpts_pkg::ST_HALTED;
		res.tid = stopped ? 4'd0 : cur_tid;
		res.run_ok = !stopped;
		return res;
	endfunction

	// ready threads other than the runner once it stops being ready
	function automatic int others_ready(bit count_waiter);
		int n = 0;
		for (int i = 0; i < NT; i++)
			if (slot_used[i] && !slot_blocked[i] && i != cur_tid)
				n++;
		if (count_waiter && slot_waiter[cur_tid] != 0)
			n++;
		return n;
	endfunction

	task automatic send_event(logic [2:0] o, logic [3:0] tgt, bit fixed, sched_result_t typed);
		sched_result_t res;
		res = apply_event(o, tgt);
		pending_results.push_back(fixed ? typed : res);
		@(negedge clk);
		in_valid <= 1'b1;
		op       <= o;
		join_tid <= tgt;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic pause_sender(int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// drain every outstanding result, then let the sequencer settle
	task automatic wait_drained();
		pause_sender(0);
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == mpts_pkg::CFG_POLICY)
			mode_psjf = data[0];
		else
			quantum = data;
	endtask

	// random event, steered away from halting until the end of the run
	task automatic send_random();
		logic [2:0] o;
		logic [3:0] tgt;
		int roll;
		sched_result_t none;
		none = '{tid: '0, run_ok: 1'b0, created: '0, sw: 1'b0, st: mpts_pkg::ST_OK};
		roll = $urandom_range(0, 99);
		tgt  = 4'($urandom_range(0, 15));
		if (roll < 18)      o = mpts_pkg::OP_CREATE;
		else if (roll < 55) o = mpts_pkg::OP_TICK;
		else if (roll < 68) o = mpts_pkg::OP_YIELD;
		else if (roll < 82) o = mpts_pkg::OP_EXIT;
		else if (roll < 96) o = mpts_pkg::OP_JOIN;
		else                o = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		if (o == mpts_pkg::OP_EXIT && others_ready(1'b1) == 0)
			o = mpts_pkg::OP_CREATE;
		if (o == mpts_pkg::OP_JOIN && others_ready(1'b0) == 0 && slot_used[tgt]
			&& tgt != cur_tid)
			o = mpts_pkg::OP_YIELD;
		send_event(o, tgt, 1'b0, none);
	endtask

	// receiver: stall pattern that changes character now and then,
	// plus long hold-offs on request
	initial begin
		int seen = 0;
		int hold_left = 0;
		int pct = 0;
		int span = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != seen) begin
				seen = hold_requests;
				hold_left = 300;
			end
			if (span == 0) begin
				span = $urandom_range(10, 80);
				case ($urandom_range(0, 3))
					0: pct = 0;
					1: pct = 25;
					2: pct = 50;
					default: pct = 85;
				endcase
			end
			span--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no event outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (running_tid !== want.tid) begin
					$error("running_tid expected %0d got %0d", want.tid, running_tid);
					fail_count++;
				end
				if (running_valid !== want.run_ok) begin
					$error("running_valid expected %0d got %0d", want.run_ok, running_valid);
					fail_count++;
				end
				if (new_tid !== want.created) begin
					$error("new_tid expected %0d got %0d", want.created, new_tid);
					fail_count++;
				end
				if (switched !== want.sw) begin
					$error("switched expected %0d got %0d", want.sw, switched);
					fail_count++;
				end
				if (status !== want.st) begin
					$error("status expected %0d got %0d", want.st, status);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		event_row_t rows[$];
		sched_result_t none;
		int burst;
		int guard;
		logic [15:0] q_set [6];
		logic        m_set [6];

		none = '{tid: '0, run_ok: 1'b0, created: '0, sw: 1'b0, st: mpts_pkg::ST_OK};
		fail_count = 0;
		hold_requests = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = mpts_pkg::OP_CREATE;
		join_tid = '0;
		cfg_we = 1'b0;
		cfg_index = mpts_pkg::CFG_POLICY;
		cfg_data = '0;

		// shadow state after reset: thread 0 runs
		mode_psjf = 1'b0;
		quantum = mpts_pkg::RESET_QUANTUM;
		for (int i = 0; i < NT; i++) begin
			slot_used[i] = (i == 0);
			slot_blocked[i] = 1'b0;
			slot_level[i] = '0;
			slot_elapsed[i] = '0;
			slot_ticks[i] = mpts_pkg::RESET_QUANTUM;
			slot_rank[i] = '0;
			slot_waiter[i] = '0;
		end
		cur_tid = '0;
		stopped = 1'b0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed events in reset configuration
		rows.push_back('{mpts_pkg::OP_CREATE, 4'd0, 1,
			'{4'd0, 1'b1, 4'd1, 1'b0, mpts_pkg::ST_OK}});
		rows.push_back('{mpts_pkg::OP_JOIN, 4'd0, 1,
			'{4'd0, 1'b1, 4'd0, 1'b0, mpts_pkg::ST_ABSENT}});  // self
		rows.push_back('{mpts_pkg::OP_JOIN, TID_TOP, 1,
			'{4'd0, 1'b1, 4'd0, 1'b0, mpts_pkg::ST_ABSENT}}); // empty slot
		rows.push_back('{OP_SPARE_HI, TID_TOP, 1,
			'{4'd0, 1'b1, 4'd0, 1'b0, mpts_pkg::ST_OK}});
		rows.push_back('{mpts_pkg::OP_YIELD, 4'd0, 0, none});
		for (int i = 0; i < 14; i++)
			rows.push_back('{mpts_pkg::OP_CREATE, 4'(i), 0, none});
		rows.push_back('{mpts_pkg::OP_CREATE, TID_TOP, 1,
			'{4'd1, 1'b1, 4'd0, 1'b0, mpts_pkg::ST_FULL}}); // table full
		rows.push_back('{mpts_pkg::OP_TICK, 4'd0, 0, none});
		rows.push_back('{mpts_pkg::OP_JOIN, TID_TOP, 0, none});
		rows.push_back('{mpts_pkg::OP_EXIT, 4'd0, 0, none});
		rows.push_back('{OP_SPARE_LO, 4'd3, 0, none});
		rows.push_back('{OP_SPARE_MID, 4'd12, 0, none});
		foreach (rows[i])
			send_event(rows[i].o, rows[i].tgt, rows[i].fixed, rows[i].res);
		wait_drained();

		// random phases over several settings, extremes included
		q_set = '{16'd1, 16'd2, 16'hffff, 16'd3, 16'd10, 16'd0};
		m_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		q_set[5] = 16'($urandom_range(1, 8));
		for (int p = 0; p < 6; p++) begin
			write_reg(mpts_pkg::CFG_POLICY, {15'd0, m_set[p]});
			write_reg(mpts_pkg::CFG_QUANTUM, q_set[p]);
			// long receiver hold-off while events keep coming
			if (p == 2)
				hold_requests++;
			burst = $urandom_range(1, 20);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_random();
				if (--burst == 0) begin
					burst = $urandom_range(1, 20);
					if ($urandom_range(0, 2) != 0)
						pause_sender($urandom_range(0, 40));
				end
			end
			// sender waits for every result before reconfiguring
			wait_drained();
		end

		// run down to the halted state, then events that are all refused
		guard = 0;
		while (!stopped && guard < 40) begin
			send_event(mpts_pkg::OP_EXIT, 4'd0, 1'b0, none);
			guard++;
		end
		send_event(mpts_pkg::OP_TICK, 4'd0, 1'b0, none);
		send_event(mpts_pkg::OP_CREATE, 4'd0, 1'b0, none);
		send_event(mpts_pkg::OP_JOIN, 4'd1, 1'b0, none);
		pause_sender(0);

		guard = 0;
		while (pending_results.size() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
